// File: src/ssti_pkg.sv
package ssti_pkg;
    localparam int ANGLE_SLOTS   = 360;
    localparam int SLOT_W        = 9;
    localparam int VALUE_W       = 18;
    localparam int FRACTION_BITS = 16;
    localparam int COUNT_W       = 9;
    localparam int DIFF_W        = VALUE_W + 1;
    localparam int PROD_W        = DIFF_W + SLOT_W;

    localparam logic [2:0] ST_EXACT  = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_STORED = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_BADVAL = 3'd4;
    localparam logic [2:0] ST_BADANG = 3'd5;
    localparam logic [2:0] ST_EMPTY  = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ANGLE_SLOTS - 1);
    localparam logic signed [VALUE_W-1:0] ONE_Q = VALUE_W'(1 << FRACTION_BITS);

    typedef struct packed {
        logic                      start;
        logic [PROD_W-1:0]         dividend;
        logic [SLOT_W-1:0]         divisor;
    } t_div_req;
endpackage

// File: src/ssti_div.sv
// Restoring divider, unsigned magnitude, one quotient bit per cycle.
module ssti_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssti_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [ssti_pkg::PROD_W-1:0]   o_quot
);
    import ssti_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] r_q, n_q;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [SLOT_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;
    logic [SLOT_W:0]   w_trial;

    // Shift in one dividend bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_q[PROD_W-1]};
        n_q     = {r_q[PROD_W-2:0], 1'b0};
        n_rem   = w_trial[SLOT_W-1:0];
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = SLOT_W'(w_trial - {1'b0, r_den});
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: src/sparse_sine_table_interpolator.sv
// Sparse sine table over whole-degree slots 0..359, values signed Q1.16.
// Each slot lives in one synchronous memory word as a valid bit over its
// value. After reset a clearing pass writes every slot invalid, one slot a
// cycle, and the input is not ready until it ends. One item is in work at a
// time, so a read never overlaps a pending write to the same slot. Bad value
// loads, bad angle queries and empty queries go straight to the output; loads
// and exact queries first take one memory read of the slot. A missed query
// reads every slot in turn to find the neighbors below and above the angle,
// then forms (ve - vb) * offset, runs the shift-subtract divider and writes
// the interpolated value back into its slot; when the table holds a single
// entry it returns that entry's value without dividing. The output register
// lets the next item be accepted while a result waits.
module sparse_sine_table_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // angle[15:0], entry_value[33:16], pad
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // sine_value[17:0], status[20:18],
                                       // entry_count[29:21], pad
);
    import ssti_pkg::*;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_LOOK = 4'd3,
                           S_SCAN = 4'd4, S_SCEND = 4'd5, S_PICK = 4'd6,
                           S_MUL = 4'd7, S_DST = 4'd8, S_DIV = 4'd9, S_WB = 4'd10,
                           S_OUT = 4'd11;

    logic [3:0]                 r_st;
    logic                       r_mode;
    logic signed [VALUE_W-1:0]  r_val;
    logic [SLOT_W-1:0]          r_key;
    logic [COUNT_W-1:0]         r_count;
    logic signed [VALUE_W-1:0]  r_vb;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [SLOT_W-1:0]          r_gap, r_off;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic signed [VALUE_W-1:0]  r_res;
    logic [2:0]                 r_status;

    // neighbor search registers
    logic [SLOT_W-1:0]          r_scan, r_pslot;
    logic                       r_pv, r_any, r_lo_ok, r_hi_ok;
    logic [SLOT_W-1:0]          r_first, r_last, r_lo, r_hi;
    logic signed [VALUE_W-1:0]  r_first_v, r_last_v, r_lo_v, r_hi_v;

    // output register
    logic                       r_ovalid;
    logic [31:0]                r_odata;

    // table memory: valid bit over the value
    logic [VALUE_W:0]           mem [ANGLE_SLOTS];
    logic                       w_we;
    logic [SLOT_W-1:0]          w_waddr, w_raddr;
    logic [VALUE_W:0]           w_wdata, r_rdata;
    logic                       w_hit;
    logic signed [VALUE_W-1:0]  w_rval;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    assign w_hit  = r_rdata[VALUE_W];
    assign w_rval = r_rdata[VALUE_W-1:0];

    // key reduction modulo 360 for loads (angle + 32768 offset split)
    logic [16:0] w_u;
    logic [SLOT_W-1:0] w_key;
    always_comb begin
        logic [16:0] q;
        logic [26:0] p;
        logic [16:0] rem;
        w_u = 17'(s_axis_tdata[15:0] ^ 16'h8000);     // angle + 32768
        p   = 27'(w_u) * 27'd728;                      // /360 via 2^18, low by <1
        q   = 17'(p >> 18);
        rem = 17'(w_u - 17'(q * 17'd360));
        if (rem >= 17'd360) rem = rem - 17'd360;
        // 32768 mod 360 = 8, subtract it back
        if (rem >= 17'd8) w_key = SLOT_W'(rem - 17'd8);
        else              w_key = SLOT_W'(rem + 17'd352);
    end

    // early status checks on the incoming transfer
    logic w_badval, w_badang;
    assign w_badval = ($signed(s_axis_tdata[33:16]) < -ONE_Q)
                   || ($signed(s_axis_tdata[33:16]) > ONE_Q);
    assign w_badang = ($signed(s_axis_tdata[15:0]) < 16'sd0)
                   || ($signed(s_axis_tdata[15:0]) > 16'sd359);

    t_div_req w_req;
    logic w_ddone;
    logic [PROD_W-1:0] w_quot;
    ssti_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                    .o_done(w_ddone), .o_quot(w_quot));

    always_comb begin
        w_req.start    = (r_st == S_DST);
        w_req.dividend = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_req.divisor  = r_gap;
    end

    // pick neighbors, wrapping to the last or first valid slot
    logic [SLOT_W-1:0]          w_lo, w_hi;
    logic signed [VALUE_W-1:0]  w_vb, w_ve;
    logic signed [DIFF_W-1:0]   w_diff, w_qmag, w_sum;
    assign w_lo   = r_lo_ok ? r_lo : r_last;
    assign w_hi   = r_hi_ok ? r_hi : r_first;
    assign w_vb   = r_lo_ok ? r_lo_v : r_last_v;
    assign w_ve   = r_hi_ok ? r_hi_v : r_first_v;
    assign w_diff = DIFF_W'(w_ve) - DIFF_W'(w_vb);
    assign w_qmag = DIFF_W'(w_quot);
    assign w_sum  = DIFF_W'(r_vb) + (r_neg ? -w_qmag : w_qmag);

    assign s_axis_tready = (r_st == S_IDLE);
    assign w_raddr = (r_st == S_SCAN) ? r_scan : r_key;
    assign w_we    = (r_st == S_CLR) || (r_st == S_WB)
                  || (r_st == S_LOOK && !r_mode && !w_hit);
    assign w_waddr = (r_st == S_CLR) ? r_scan : r_key;
    assign w_wdata = (r_st == S_CLR) ? '0 : {1'b1, (r_st == S_WB) ? r_res : r_val};

    logic w_oslot;
    assign w_oslot = !r_ovalid || m_axis_tready;

    // advance the slot pointer for the clearing pass and the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= (r_st == S_SCAN);
            if (r_st == S_CLR || r_st == S_SCAN)
                r_scan <= (r_scan == LAST_SLOT) ? '0 : r_scan + 1'b1;
        end
    end

    // track first, last and nearest valid slots as read data returns
    always_ff @(posedge i_clk) begin
        r_pslot <= r_scan;
        if (r_st == S_LOOK) begin
            r_any   <= 1'b0;
            r_lo_ok <= 1'b0;
            r_hi_ok <= 1'b0;
        end else if (r_pv && w_hit) begin
            if (!r_any) begin
                r_first   <= r_pslot;
                r_first_v <= w_rval;
            end
            r_any    <= 1'b1;
            r_last   <= r_pslot;
            r_last_v <= w_rval;
            if (r_pslot < r_key) begin
                r_lo    <= r_pslot;
                r_lo_v  <= w_rval;
                r_lo_ok <= 1'b1;
            end
            if (r_pslot > r_key && !r_hi_ok) begin
                r_hi    <= r_pslot;
                r_hi_v  <= w_rval;
                r_hi_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_count <= '0;
        end else begin
            case (r_st)
                S_CLR: if (r_scan == LAST_SLOT) r_st <= S_IDLE;
                S_IDLE: if (s_axis_tvalid) begin
                    r_mode <= s_axis_tuser;
                    r_val  <= s_axis_tdata[33:16];
                    r_key  <= s_axis_tuser ? s_axis_tdata[SLOT_W-1:0] : w_key;
                    r_res  <= '0;
                    if (!s_axis_tuser && w_badval) begin
                        r_status <= ST_BADVAL;
                        r_st     <= S_OUT;
                    end else if (s_axis_tuser && w_badang) begin
                        r_status <= ST_BADANG;
                        r_st     <= S_OUT;
                    end else if (s_axis_tuser && r_count == '0) begin
                        r_status <= ST_EMPTY;
                        r_st     <= S_OUT;
                    end else begin
                        r_st <= S_RD;
                    end
                end
                S_RD: r_st <= S_LOOK;
                // slot word is back: store, flag duplicate, hit or start search
                S_LOOK: begin
                    if (!r_mode) begin
                        if (w_hit) begin
                            r_status <= ST_DUP;
                        end else begin
                            r_status <= ST_STORED;
                            r_count  <= r_count + 1'b1;
                        end
                        r_st <= S_OUT;
                    end else if (w_hit) begin
                        r_status <= ST_EXACT;
                        r_res    <= w_rval;
                        r_st     <= S_OUT;
                    end else begin
                        r_status <= ST_INTERP;
                        r_st     <= S_SCAN;
                    end
                end
                S_SCAN: if (r_scan == LAST_SLOT) r_st <= S_SCEND;
                S_SCEND: r_st <= S_PICK;
                // single entry returns its value; otherwise set up the division
                S_PICK: begin
                    r_vb <= w_vb;
                    if (w_lo == w_hi) begin
                        r_res <= w_vb;
                        r_st  <= S_OUT;
                    end else begin
                        r_diff <= w_diff;
                        r_gap  <= (w_hi > w_lo) ? SLOT_W'(w_hi - w_lo)
                                : SLOT_W'(w_hi + SLOT_W'(ANGLE_SLOTS) - w_lo);
                        r_off  <= (r_key > w_lo) ? SLOT_W'(r_key - w_lo)
                                : SLOT_W'(r_key + SLOT_W'(ANGLE_SLOTS) - w_lo);
                        r_st   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= PROD_W'(r_diff) * $signed({1'b0, r_off});
                    r_st   <= S_DST;
                end
                S_DST: begin
                    r_neg <= r_prod[PROD_W-1];
                    r_st  <= S_DIV;
                end
                S_DIV: if (w_ddone) begin
                    r_res <= VALUE_W'(w_sum);
                    r_st  <= S_WB;
                end
                S_WB: begin
                    r_count <= r_count + 1'b1;
                    r_st    <= S_OUT;
                end
                S_OUT: if (w_oslot) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_st == S_OUT && w_oslot) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && w_oslot) r_odata <= {2'b0, r_count, r_status, r_res};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && w_oslot) |=> r_ovalid) else $error("result lost");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_st == S_IDLE)) else $error("ready out of idle");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= COUNT_W'(ANGLE_SLOTS))) else $error("count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while waiting");
endmodule

// File: tb/tb.sv
module tb;
    import ssti_pkg::*;

    // one expected result of the table
    typedef struct {
        logic signed [VALUE_W-1:0] sine;
        logic [2:0]                status;
        logic [COUNT_W-1:0]        count;
    } t_sine_result;

    // scoreboard: table predictor plus queue of pending results
    class sine_table_board;
        bit                        slot_valid [ANGLE_SLOTS];
        logic signed [VALUE_W-1:0] slot_value [ANGLE_SLOTS];
        int                        slot_count;
        t_sine_result              pending [$];
        int                        mismatches;
        int                        checked;
        int                        status_seen [8];

        function void note_item(bit is_query, logic signed [15:0] ang,
                                logic signed [VALUE_W-1:0] val);
            t_sine_result r;
            int key, lo, hi, first, last, gap, off;
            longint vb, ve, v;
            r.sine = '0;
            if (!is_query) begin
                key = ang % ANGLE_SLOTS;
                if (key < 0) key += ANGLE_SLOTS;
                if (val < -ONE_Q || val > ONE_Q) r.status = ST_BADVAL;
                else if (slot_valid[key]) r.status = ST_DUP;
                else begin
                    slot_valid[key] = 1'b1;
                    slot_value[key] = val;
                    slot_count++;
                    r.status = ST_STORED;
                end
            end else if (ang < 0 || ang >= ANGLE_SLOTS) begin
                r.status = ST_BADANG;
            end else if (slot_count == 0) begin
                r.status = ST_EMPTY;
            end else if (slot_valid[ang]) begin
                r.status = ST_EXACT;
                r.sine = slot_value[ang];
            end else begin
                r.status = ST_INTERP;
                lo = -1; hi = -1; first = -1; last = -1;
                for (int i = 0; i < ANGLE_SLOTS; i++) begin
                    if (slot_valid[i]) begin
                        if (first < 0) first = i;
                        last = i;
                        if (i < ang) lo = i;
                        if (i > ang && hi < 0) hi = i;
                    end
                end
                if (lo < 0) lo = last;
                if (hi < 0) hi = first;
                if (lo == hi) begin
                    r.sine = slot_value[lo];
                end else begin
                    gap = (hi - lo + ANGLE_SLOTS) % ANGLE_SLOTS;
                    off = (ang - lo + ANGLE_SLOTS) % ANGLE_SLOTS;
                    vb = slot_value[lo];
                    ve = slot_value[hi];
                    // SV division truncates toward zero
                    v = vb + ((ve - vb) * off) / gap;
                    r.sine = v[VALUE_W-1:0];
                    slot_valid[ang] = 1'b1;
                    slot_value[ang] = r.sine;
                    slot_count++;
                end
            end
            r.count = slot_count[COUNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            t_sine_result e;
            logic signed [VALUE_W-1:0] s;
            logic [2:0]                st;
            logic [COUNT_W-1:0]        c;
            s  = data[17:0];
            st = data[20:18];
            c  = data[29:21];
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sine %0d status %0d count %0d", s, st, c);
                return;
            end
            e = pending.pop_front();
            status_seen[e.status]++;
            if (s !== e.sine || st !== e.status || c !== e.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp sine %0d status %0d count %0d, got %0d %0d %0d",
                             e.sine, e.status, e.count, s, st, c);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // angle[15:0], entry_value[33:16], pad
    logic        s_axis_tuser = 0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // sine_value[17:0], status[20:18], entry_count[29:21]

    sine_table_board board = new();
    int              stall_mode;

    sparse_sine_table_interpolator u_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always #10 i_clk = ~i_clk;

    // receiver: check each transfer, stall on a shifting pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial stall_mode = 0;
    always begin
        repeat (200) @(posedge i_clk);
        stall_mode = $urandom_range(0, 2);
    end

    int burst_left = 0;

    // send one item, holding it until the transfer; gaps between bursts
    task automatic send_item(bit is_query, logic signed [15:0] ang,
                             logic signed [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) * $urandom_range(1, 30);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_query;
        s_axis_tdata  <= {6'b0, val, ang};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(is_query, ang, val);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_value(output logic signed [VALUE_W-1:0] v);
        case ($urandom_range(0, 9))
            0: v = VALUE_W'($urandom);
            1: v = ($urandom_range(0, 1)) ? ONE_Q : -ONE_Q;
            default: v = VALUE_W'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endtask

    initial begin
        logic signed [VALUE_W-1:0] v;
        logic signed [15:0]        a;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, bad angles, bad values, extremes, single entry
        send_item(1'b1, 16'sd10, '0);
        send_item(1'b1, -16'sd1, '0);
        send_item(1'b1, 16'sd360, '0);
        send_item(1'b1, 16'sh7fff, '0);
        send_item(1'b1, 16'sh8000, '0);
        send_item(1'b0, 16'sd5, ONE_Q + 18'sd1);
        send_item(1'b0, 16'sd5, -ONE_Q - 18'sd1);
        send_item(1'b0, 16'sd5, 18'sh1ffff);
        send_item(1'b0, 16'sd5, 18'sh20000);
        send_item(1'b0, 16'sd90, ONE_Q);
        send_item(1'b1, 16'sd200, '0);
        send_item(1'b1, 16'sd90, '0);
        send_item(1'b0, 16'sd450, '0);
        send_item(1'b0, -16'sd90, -ONE_Q);
        send_item(1'b0, 16'sh8000, 18'sd1234);
        send_item(1'b0, 16'sh7fff, -18'sd1);
        send_item(1'b1, 16'sd0, '0);
        send_item(1'b1, 16'sd359, '0);
        send_item(1'b1, 16'sd180, '0);
        send_item(1'b1, 16'sd180, '0);
        send_item(1'b1, 16'sd100, '0);
        send_item(1'b0, 16'sd0, 18'sd7);
        wait_drain();

        // random: mostly in-range queries and loads, some wide noise
        for (int n = 0; n < 1000; n++) begin
            random_value(v);
            case ($urandom_range(0, 9))
                0: a = 16'($urandom);
                1, 2, 3: a = 16'($signed($urandom_range(0, 1440)) - 720);
                default: a = 16'($urandom_range(0, 359));
            endcase
            send_item(($urandom_range(0, 9) < 6), a, v);
            if (n == 500) wait_drain();
        end

        wait_drain();
        $display("checked %0d results: exact %0d interp %0d stored %0d dup %0d",
                 board.checked, board.status_seen[ST_EXACT], board.status_seen[ST_INTERP],
                 board.status_seen[ST_STORED], board.status_seen[ST_DUP]);
        $display("bad value %0d, bad angle %0d, empty %0d; final count %0d",
                 board.status_seen[ST_BADVAL], board.status_seen[ST_BADANG],
                 board.status_seen[ST_EMPTY], board.slot_count);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout: room for the worst-case item time plus stalls and gaps
    initial begin
        #100000000;
        $display("FAIL");
        $finish;
    end
endmodule
